[design/jtms_pkg.sv]
// Shared types and constants for the two-machine sequencer.
// Used by jtms_ctrl, jtms_dp and johnson_two_machine_sequencer_unit.
`timescale 1ns / 1ps
`default_nettype none

package jtms_pkg;

  localparam int MaxJobsDef = 16;

  localparam int TimeW   = 16;
  localparam int JobW    = 2 * TimeW;
  localparam int IndexW  = 4;
  localparam int Fin1W   = 21;
  localparam int Fin2W   = 22;
  localparam int Fin1OutW = 20;
  localparam int Fin2OutW = 21;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPlace,
    StSlotRd,
    StJobRd,
    StFin1,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_run;
    logic place;
    logic slot_rd;
    logic job_rd;
    logic fin1;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic place_last;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

[design/jtms_ctrl.sv]
// Controller: sequences loading, selection scans, placement and result emission.
// Depends on jtms_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module jtms_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic           last_job_i,
  input  jtms_pkg::sts_t      sts_i,
  output jtms_pkg::cmd_t      cmd_o,
  output logic                busy_o
);
  import jtms_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_job_i) begin
            cmd_o.scan_clr = 1'b1;
            state_d        = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = StPlace;
        end
      end
      StPlace: begin
        cmd_o.place = 1'b1;
        if (sts_i.place_last) begin
          state_d = StSlotRd;
        end else begin
          // start the next pass over the remaining jobs
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StSlotRd: begin
        cmd_o.slot_rd = 1'b1;
        state_d       = StJobRd;
      end
      StJobRd: begin
        cmd_o.job_rd = 1'b1;
        state_d      = StFin1;
      end
      StFin1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_last) begin
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end else begin
          state_d = StSlotRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/jtms_dp.sv]
// Datapath: job store, sequence slot memory, taken marks, min scan and finish times.
// Depends on jtms_pkg; driven by commands from jtms_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module jtms_dp #(
  parameter int MaxJobs = jtms_pkg::MaxJobsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  jtms_pkg::cmd_t                     cmd_i,
  output jtms_pkg::sts_t                     sts_o,
  input  wire logic [jtms_pkg::TimeW-1:0]    time_m1_i,
  input  wire logic [jtms_pkg::TimeW-1:0]    time_m2_i,
  input  wire logic                          last_job_i,
  output logic                               valid_o,
  output logic [jtms_pkg::IndexW-1:0]        job_index_o,
  output logic [jtms_pkg::TimeW-1:0]         out_time_m1_o,
  output logic [jtms_pkg::TimeW-1:0]         out_time_m2_o,
  output logic [jtms_pkg::Fin1OutW-1:0]      finish_m1_o,
  output logic [jtms_pkg::Fin2OutW-1:0]      finish_m2_o,
  output logic                               last_in_sequence_o
);
  import jtms_pkg::*;

  localparam int IdxW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int CntW = $clog2(MaxJobs + 1);

  logic [JobW-1:0]  store_mem [MaxJobs];
  logic [IdxW-1:0]  slot_mem  [MaxJobs];
  logic [MaxJobs-1:0] taken_q;

  logic [CntW-1:0]  total_q, front_q, back_q, scan_cnt_q, placed_q, emit_k_q;
  logic [CntW-1:0]  total_inc;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [JobW-1:0]  rd_data_q;
  logic             found_q;
  logic [TimeW-1:0] best_q, pick_t1_q, pick_t2_q;
  logic [IdxW-1:0]  pick_q;
  logic [IdxW-1:0]  slot_q;
  logic [Fin1W-1:0] fin1_q;
  logic [Fin2W-1:0] fin2_q, fin2_d;
  logic             valid_q;

  logic             store_full;
  logic             rd_en, scan_issue;
  logic [IdxW-1:0]  rd_addr;
  logic [TimeW-1:0] cur_t1, cur_t2, cur_min;
  logic             take_cur;
  logic [Fin2W-1:0] fin1_ext;

  assign store_full = (total_q == CntW'(MaxJobs));
  assign total_inc  = store_full ? total_q : CntW'(total_q + 1'b1);

  assign scan_issue = cmd_i.scan_run && (scan_cnt_q < total_q);
  assign rd_en      = scan_issue || cmd_i.job_rd;
  assign rd_addr    = cmd_i.job_rd ? slot_q : scan_cnt_q[IdxW-1:0];

  assign cur_t1   = rd_data_q[TimeW-1:0];
  assign cur_t2   = rd_data_q[JobW-1:TimeW];
  assign cur_min  = (cur_t1 < cur_t2) ? cur_t1 : cur_t2;
  // later job wins a tie, so compare with <=
  assign take_cur = rd_vld_q && !taken_q[rd_idx_q] && (!found_q || cur_min <= best_q);

  assign fin1_ext = Fin2W'(fin1_q);
  assign fin2_d   = ((fin1_ext > fin2_q) ? fin1_ext : fin2_q) + Fin2W'(cur_t2);

  assign sts_o.scan_done  = (scan_cnt_q == total_q) && !rd_vld_q;
  assign sts_o.place_last = ((CntW + 1)'(placed_q) + 1'b1) == (CntW + 1)'(total_q);
  assign sts_o.emit_last  = ((CntW + 1)'(emit_k_q) + 1'b1) == (CntW + 1)'(total_q);

  // job store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !store_full) begin
      store_mem[total_q[IdxW-1:0]] <= {time_m2_i, time_m1_i};
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  // sequence slots: written at placement, read registered during emission
  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      if (pick_t1_q < pick_t2_q) begin
        slot_mem[front_q[IdxW-1:0]] <= pick_q;
      end else begin
        slot_mem[back_q[IdxW-1:0]] <= pick_q;
      end
    end
    if (cmd_i.slot_rd) begin
      slot_q <= slot_mem[emit_k_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      front_q    <= '0;
      back_q     <= '0;
      scan_cnt_q <= '0;
      placed_q   <= '0;
      emit_k_q   <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      taken_q    <= '0;
      fin1_q     <= '0;
      fin2_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        total_q <= total_inc;
        if (last_job_i) begin
          front_q <= '0;
          back_q  <= CntW'(total_inc - 1'b1);
        end
      end
      if (cmd_i.scan_clr) begin
        scan_cnt_q <= '0;
        rd_vld_q   <= 1'b0;
        found_q    <= 1'b0;
      end else begin
        rd_vld_q <= scan_issue;
        if (scan_issue) begin
          scan_cnt_q <= CntW'(scan_cnt_q + 1'b1);
        end
        if (take_cur) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.place) begin
        taken_q[pick_q] <= 1'b1;
        placed_q        <= CntW'(placed_q + 1'b1);
        if (pick_t1_q < pick_t2_q) begin
          front_q <= CntW'(front_q + 1'b1);
        end else begin
          back_q <= CntW'(back_q - 1'b1);
        end
      end
      if (cmd_i.fin1) begin
        fin1_q <= fin1_q + Fin1W'(cur_t1);
      end
      if (cmd_i.emit && !cmd_i.clear) begin
        fin2_q   <= fin2_d;
        emit_k_q <= CntW'(emit_k_q + 1'b1);
      end
      // drop the whole set once the final result goes out
      if (cmd_i.clear) begin
        total_q  <= '0;
        front_q  <= '0;
        back_q   <= '0;
        placed_q <= '0;
        emit_k_q <= '0;
        taken_q  <= '0;
        fin1_q   <= '0;
        fin2_q   <= '0;
      end
    end
  end

  // scan payload: index of the issued read and the best candidate so far
  always_ff @(posedge clk_i) begin
    if (scan_issue) begin
      rd_idx_q <= scan_cnt_q[IdxW-1:0];
    end
    if (take_cur && !cmd_i.scan_clr) begin
      best_q    <= cur_min;
      pick_q    <= rd_idx_q;
      pick_t1_q <= cur_t1;
      pick_t2_q <= cur_t2;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      job_index_o        <= IndexW'(slot_q);
      out_time_m1_o      <= cur_t1;
      out_time_m2_o      <= cur_t2;
      finish_m1_o        <= fin1_q[Fin1OutW-1:0];
      finish_m2_o        <= fin2_d[Fin2OutW-1:0];
      last_in_sequence_o <= sts_o.emit_last;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

[design/johnson_two_machine_sequencer_unit.sv]
// Top level of the two-machine Johnson-rule sequencer.
// Instantiates jtms_ctrl and jtms_dp; depends on jtms_pkg.
//
//   Channel   Handshake          Ports
//   request   start / busy       time_m1_i, time_m2_i, last_job_i
//   result    valid_o strobe     job_index_o, out_time_m1_o, out_time_m2_o,
//                                finish_m1_o, finish_m2_o, last_in_sequence_o
//
// A request without last_job_i loads one job; busy stays low.
// A request with last_job_i starts sequencing n stored jobs, which holds busy
// while it runs: each of n placements scans the job store through its single
// read port, one entry a cycle, then each result goes through slot read, job read, finish update and emit.
// Reset is asynchronous and clears the set. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module johnson_two_machine_sequencer_unit #(
  parameter int MaxJobs = jtms_pkg::MaxJobsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [jtms_pkg::TimeW-1:0]    time_m1_i,
  input  wire logic [jtms_pkg::TimeW-1:0]    time_m2_i,
  input  wire logic                          last_job_i,
  output logic                               valid_o,
  output logic [jtms_pkg::IndexW-1:0]        job_index_o,
  output logic [jtms_pkg::TimeW-1:0]         out_time_m1_o,
  output logic [jtms_pkg::TimeW-1:0]         out_time_m2_o,
  output logic [jtms_pkg::Fin1OutW-1:0]      finish_m1_o,
  output logic [jtms_pkg::Fin2OutW-1:0]      finish_m2_o,
  output logic                               last_in_sequence_o
);
  import jtms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  jtms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .last_job_i (last_job_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  jtms_dp #(
    .MaxJobs (MaxJobs)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .time_m1_i          (time_m1_i),
    .time_m2_i          (time_m2_i),
    .last_job_i         (last_job_i),
    .valid_o            (valid_o),
    .job_index_o        (job_index_o),
    .out_time_m1_o      (out_time_m1_o),
    .out_time_m2_o      (out_time_m2_o),
    .finish_m1_o        (finish_m1_o),
    .finish_m2_o        (finish_m2_o),
    .last_in_sequence_o (last_in_sequence_o)
  );

`ifndef SYNTHESIS
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_job_i) |=> !busy)
    else $error("loading request started sequencing");

  a_last_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_in_sequence_o) |-> !busy)
    else $error("final result while still busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for two cycles");

  a_result_while_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_in_sequence_o) |-> busy)
    else $error("intermediate result while idle");
`endif

endmodule

`default_nettype wire
